// ===== hw/rtl/rrtp_pkg.sv =====
// Shared types and codes for the round robin thread picker.
package rrtp_pkg;

    // Slot status as kept in the slot table
    typedef enum logic [2:0] {
        ST_EMPTY      = 3'd0,
        ST_READY      = 3'd1,
        ST_BLOCKED    = 3'd2,
        ST_TERMINATED = 3'd3,
        ST_RUNNING    = 3'd4
    } slot_state_t;

    // Event codes
    localparam logic [2:0] MODE_YIELD  = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_WAKE   = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_DYING  = 3'd4;

    // Status requested for the old thread on a yield
    localparam logic [1:0] YS_READY   = 2'd0;
    localparam logic [1:0] YS_BLOCKED = 2'd1;

    // Error codes
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_EMPTY      = 2'd1;
    localparam logic [1:0] ERR_TERMINATED = 2'd2;
    localparam logic [1:0] ERR_OCCUPIED   = 2'd3;

    // One slot table entry
    typedef struct packed {
        slot_state_t state;
        logic        dying;
        logic        waits;
    } slot_entry_t;

    // Request word
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot;
        logic [1:0]  yield_status;
        logic        wait_on_handle;
        logic [15:0] handle_ready;
    } req_t;

    // Response word
    typedef struct packed {
        logic [3:0] chosen_slot;
        logic       found;
        logic [1:0] error;
    } rsp_t;

endpackage

// ===== hw/rtl/rrtp_slot_table.sv =====
// Slot table memory with per-entry valid bits; unwritten entries read as empty.
module rrtp_slot_table #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output rrtp_pkg::slot_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  rrtp_pkg::slot_entry_t wr_data
);

    rrtp_pkg::slot_entry_t mem [SLOTS];
    rrtp_pkg::slot_entry_t rd_data_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic                  rd_valid_reg;

    // Write entries and read with a registered port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track which entries hold written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Present an unwritten entry as empty
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/round_robin_thread_picker.sv =====
// Top level of the round robin thread picker: event sequencer over the slot table.
//
// One request word gives one response word. Add, wake, remove and mark-dying
// events go through one table read, one evaluate-and-write and the load of the
// response register. A yield walks the other SLOTS-1 slots round robin through
// the single table read port, one slot per cycle, and stops early when a winner
// turns up; the old thread is then read and rewritten. The request side stalls
// while an event is in progress, and a finished response may wait in its
// register while the next request is taken. Slot indexes at or above SLOTS act
// as empty slots, and an add to one is refused with ERR_EMPTY; only slots 0 to
// 15 have a handle_ready bit.
module round_robin_thread_picker #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rrtp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrtp_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_SCAN,
        S_OLD_RD,
        S_OLD_EV,
        S_FIN
    } seq_state_t;

    seq_state_t            state_reg, state_next;
    rrtp_pkg::req_t        req_reg, req_next;
    logic [IDX_W-1:0]      running_reg, running_next;
    logic [IDX_W-1:0]      win_reg, win_next;
    logic [IDX_W-1:0]      issue_addr_reg, issue_addr_next;
    logic [IDX_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic                  issue_done_reg, issue_done_next;
    logic [IDX_W-1:0]      eval_addr_reg, eval_addr_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic                  eval_last_reg, eval_last_next;
    logic                  found_reg, found_next;
    logic [1:0]            err_reg, err_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rrtp_pkg::rsp_t        rsp_reg, rsp_next;

    logic                  tbl_rd_en;
    logic [IDX_W-1:0]      tbl_rd_addr;
    rrtp_pkg::slot_entry_t tbl_rd_data;
    logic                  tbl_wr_en;
    logic [IDX_W-1:0]      tbl_wr_addr;
    rrtp_pkg::slot_entry_t tbl_wr_data;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        next_idx = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    rrtp_slot_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    // Sequence events through the table
    always_comb
    begin
        logic                  in_range;
        rrtp_pkg::slot_state_t st;
        logic                  hbit;
        rrtp_pkg::slot_state_t old_ns;

        state_next      = state_reg;
        req_next        = req_reg;
        running_next    = running_reg;
        win_next        = win_reg;
        issue_addr_next = issue_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        issue_done_next = issue_done_reg;
        eval_addr_next  = eval_addr_reg;
        eval_vld_next   = 1'b0;
        eval_last_next  = eval_last_reg;
        found_next      = found_reg;
        err_next        = err_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = IDX_W'(req_reg.slot);
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = IDX_W'(req_reg.slot);
        tbl_wr_data     = tbl_rd_data;

        in_range = (32'(req_reg.slot) < 32'(SLOTS));
        st       = in_range ? tbl_rd_data.state : rrtp_pkg::ST_EMPTY;
        hbit     = (32'(eval_addr_reg) < 32'd16)
                   ? req_reg.handle_ready[4'(eval_addr_reg)] : 1'b0;
        if (req_reg.yield_status == rrtp_pkg::YS_READY)
        begin
            old_ns = rrtp_pkg::ST_READY;
        end
        else if (req_reg.yield_status == rrtp_pkg::YS_BLOCKED)
        begin
            old_ns = rrtp_pkg::ST_BLOCKED;
        end
        else
        begin
            old_ns = rrtp_pkg::ST_TERMINATED;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a word and start the target read or the lap
                if (req_valid)
                begin
                    req_next        = req;
                    tbl_rd_en       = 1'b1;
                    tbl_rd_addr     = IDX_W'(req.slot);
                    issue_addr_next = next_idx(running_reg);
                    issue_cnt_next  = '0;
                    issue_done_next = 1'b0;
                    eval_last_next  = 1'b0;
                    found_next      = 1'b0;
                    err_next        = rrtp_pkg::ERR_OK;
                    state_next      = (req.mode == rrtp_pkg::MODE_YIELD) ? S_SCAN : S_CMD;
                end
            end

            S_CMD:
            begin
                // Check the target slot and apply the event
                tbl_wr_addr = IDX_W'(req_reg.slot);
                unique case (req_reg.mode)
                    rrtp_pkg::MODE_ADD:
                    begin
                        if (!in_range)
                        begin
                            err_next = rrtp_pkg::ERR_EMPTY;
                        end
                        else if (st != rrtp_pkg::ST_EMPTY)
                        begin
                            err_next = rrtp_pkg::ERR_OCCUPIED;
                        end
                        else
                        begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_data = '{state: rrtp_pkg::ST_READY, dying: 1'b0,
                                            waits: 1'b0};
                        end
                    end
                    rrtp_pkg::MODE_WAKE:
                    begin
                        if (st == rrtp_pkg::ST_EMPTY)
                        begin
                            err_next = rrtp_pkg::ERR_EMPTY;
                        end
                        else if (st == rrtp_pkg::ST_TERMINATED)
                        begin
                            err_next = rrtp_pkg::ERR_TERMINATED;
                        end
                        else if (st != rrtp_pkg::ST_RUNNING)
                        begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_data = '{state: rrtp_pkg::ST_READY,
                                            dying: tbl_rd_data.dying, waits: 1'b0};
                        end
                    end
                    rrtp_pkg::MODE_REMOVE:
                    begin
                        if (st == rrtp_pkg::ST_EMPTY)
                        begin
                            err_next = rrtp_pkg::ERR_EMPTY;
                        end
                        else
                        begin
                            tbl_wr_en   = 1'b1;
                            tbl_wr_data = '{state: rrtp_pkg::ST_EMPTY, dying: 1'b0,
                                            waits: 1'b0};
                        end
                    end
                    rrtp_pkg::MODE_DYING:
                    begin
                        if (st == rrtp_pkg::ST_EMPTY)
                        begin
                            err_next = rrtp_pkg::ERR_EMPTY;
                        end
                        else
                        begin
                            tbl_wr_en         = 1'b1;
                            tbl_wr_data       = tbl_rd_data;
                            tbl_wr_data.dying = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = rrtp_pkg::ERR_OK;
                    end
                endcase
                state_next = S_FIN;
            end

            S_SCAN:
            begin
                // Issue the next slot read of the lap
                if (!issue_done_reg)
                begin
                    tbl_rd_en       = 1'b1;
                    tbl_rd_addr     = issue_addr_reg;
                    eval_vld_next   = 1'b1;
                    eval_addr_next  = issue_addr_reg;
                    eval_last_next  = (issue_cnt_reg == IDX_W'(SLOTS - 2));
                    issue_done_next = (issue_cnt_reg == IDX_W'(SLOTS - 2));
                    issue_addr_next = next_idx(issue_addr_reg);
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                end
                // Evaluate the slot read in the previous cycle
                if (eval_vld_reg)
                begin
                    tbl_wr_addr = eval_addr_reg;
                    if (tbl_rd_data.state == rrtp_pkg::ST_READY && tbl_rd_data.dying)
                    begin
                        tbl_wr_en         = 1'b1;
                        tbl_wr_data       = tbl_rd_data;
                        tbl_wr_data.state = rrtp_pkg::ST_TERMINATED;
                        if (eval_last_reg)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (tbl_rd_data.state == rrtp_pkg::ST_READY
                             || (tbl_rd_data.state == rrtp_pkg::ST_BLOCKED
                                 && tbl_rd_data.waits && hbit))
                    begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_data = '{state: rrtp_pkg::ST_RUNNING,
                                        dying: tbl_rd_data.dying, waits: 1'b0};
                        win_next    = eval_addr_reg;
                        state_next  = S_OLD_RD;
                    end
                    else if (eval_last_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_OLD_RD:
            begin
                // Read the old thread's entry
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = running_reg;
                state_next  = S_OLD_EV;
            end

            S_OLD_EV:
            begin
                // Hand the old thread its new status and switch over
                tbl_wr_addr = running_reg;
                if (tbl_rd_data.state == rrtp_pkg::ST_RUNNING)
                begin
                    tbl_wr_en   = 1'b1;
                    tbl_wr_data = '{state: old_ns, dying: tbl_rd_data.dying,
                                    waits: (old_ns == rrtp_pkg::ST_BLOCKED)
                                           ? req_reg.wait_on_handle : 1'b0};
                end
                running_next = win_reg;
                found_next   = 1'b1;
                state_next   = S_FIN;
            end

            S_FIN:
            begin
                // Load the response once the register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.chosen_slot = 4'(running_reg);
                    rsp_next.found       = found_reg;
                    rsp_next.error       = err_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            running_reg    <= '0;
            win_reg        <= '0;
            issue_addr_reg <= '0;
            issue_cnt_reg  <= '0;
            issue_done_reg <= 1'b0;
            eval_addr_reg  <= '0;
            eval_vld_reg   <= 1'b0;
            eval_last_reg  <= 1'b0;
            found_reg      <= 1'b0;
            err_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            running_reg    <= running_next;
            win_reg        <= win_next;
            issue_addr_reg <= issue_addr_next;
            issue_cnt_reg  <= issue_cnt_next;
            issue_done_reg <= issue_done_next;
            eval_addr_reg  <= eval_addr_next;
            eval_vld_reg   <= eval_vld_next;
            eval_last_reg  <= eval_last_next;
            found_reg      <= found_next;
            err_reg        <= err_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
